// File: rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg: shared types and constants of the base64 stream codec
// Stream state, queued result groups and register indexes.
// ----------------------------------------------------------------------------
package b64_pkg;

    // Register indexes on the configuration port (paddr[2])
    localparam logic CFG_DIRECTION = 1'b0;
    localparam logic CFG_OUT_LIMIT = 1'b1;

    // Direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Depth of the queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Most results that one item gives
    localparam int unsigned MAX_RES = 4;

    // Per-stream state
    typedef struct packed {
        logic [23:0] accum;
        logic [1:0]  pos;
        logic [1:0]  marks;
        logic [1:0]  strip;
        logic [15:0] count;
        logic        err;
    } t_b64_state;

    // Results of one item, drained one per cycle by the back unless stalled
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] data;
        logic [MAX_RES-1:0]      has;
        logic [2:0]              cnt;
        logic                    err;
        logic                    last;
    } t_b64_job;

endpackage

// File: rtl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front: item intake and classification
// Updates the stream state for each item and builds its result group.
// ----------------------------------------------------------------------------
module b64_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_direction,
    input  logic [15:0]         i_out_limit,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_in_byte,
    input  logic                i_last_item,
    input  logic                i_full,
    output logic                o_push,
    output b64_pkg::t_b64_job   o_job
);

    typedef struct packed {
        b64_pkg::t_b64_state st;
        logic                emit;
        logic [7:0]          dbyte;
    } t_dstep;

    b64_pkg::t_b64_state r_state;
    b64_pkg::t_b64_state n_state;
    b64_pkg::t_b64_state s;
    b64_pkg::t_b64_job   job;
    t_dstep              ds;
    logic [2:0]          n;
    logic                is_strip;
    logic                accept;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            c = {2'b00, v};
            if (v < 6'd26)      enc_char = 8'h41 + c;
            else if (v < 6'd52) enc_char = 8'h61 + c - 8'd26;
            else if (v < 6'd62) enc_char = 8'h30 + c - 8'd52;
            else if (v == 6'd62) enc_char = 8'h2B;
            else                enc_char = 8'h2F;
        end
    endfunction

    // 64 marks a character outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        begin
            if (c >= 8'h41 && c <= 8'h5A)      sextet_of = 7'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7A) sextet_of = 7'(c - 8'h61 + 8'd26);
            else if (c >= 8'h30 && c <= 8'h39) sextet_of = 7'(c - 8'h30 + 8'd52);
            else if (c == 8'h2B)               sextet_of = 7'd62;
            else if (c == 8'h2F)               sextet_of = 7'd63;
            else                               sextet_of = 7'd64;
        end
    endfunction

    function automatic t_dstep dec_step(input b64_pkg::t_b64_state st,
                                        input logic [6:0] v,
                                        input logic [15:0] limit);
        t_dstep     r;
        logic       bad;
        logic [5:0] vv;
        logic       want;
        begin
            r       = '0;
            r.st    = st;
            bad     = v[6];
            vv      = bad ? 6'd0 : v[5:0];
            want    = 1'b0;
            if (!st.err) begin
                unique case (st.pos)
                    2'd0: begin
                        r.st.accum = {vv, 18'd0};
                        r.st.marks = {1'b0, bad};
                        r.st.pos   = 2'd1;
                    end
                    2'd1: begin
                        r.st.marks = st.marks | {bad, 1'b0};
                        r.st.accum = st.accum | {6'd0, vv, 12'd0};
                        r.st.pos   = 2'd2;
                        if (r.st.marks != 2'b00) begin
                            r.st.err = 1'b1;
                        end else begin
                            want    = 1'b1;
                            r.dbyte = r.st.accum[23:16];
                        end
                    end
                    2'd2: begin
                        r.st.accum = st.accum | {12'd0, vv, 6'd0};
                        r.st.pos   = 2'd3;
                        want       = !bad;
                        r.dbyte    = r.st.accum[15:8];
                    end
                    default: begin
                        r.st.accum = st.accum | {18'd0, vv};
                        r.st.pos   = 2'd0;
                        want       = !bad;
                        r.dbyte    = r.st.accum[7:0];
                    end
                endcase
                // hold to the byte limit
                if (want && (st.count < limit)) begin
                    r.emit     = 1'b1;
                    r.st.count = st.count + 16'd1;
                end
            end
            dec_step = r;
        end
    endfunction

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !i_full;
    assign is_strip   = (i_in_byte == 8'h3D) || (i_in_byte == 8'h0D) ||
                        (i_in_byte == 8'h0A);

    always_comb begin
        s   = r_state;
        job = '0;
        n   = 3'd0;
        ds  = '0;
        if (i_direction == b64_pkg::DIR_ENCODE) begin
            unique case (s.pos)
                2'd0: begin
                    s.accum = {i_in_byte, 16'd0};
                    s.pos   = 2'd1;
                end
                2'd1: begin
                    s.accum = s.accum | {8'd0, i_in_byte, 8'd0};
                    s.pos   = 2'd2;
                end
                default: begin
                    s.accum     = s.accum | {16'd0, i_in_byte};
                    s.pos       = 2'd0;
                    job.data[0] = enc_char(s.accum[23:18]);
                    job.data[1] = enc_char(s.accum[17:12]);
                    job.data[2] = enc_char(s.accum[11:6]);
                    job.data[3] = enc_char(s.accum[5:0]);
                    job.has     = '1;
                    n           = 3'd4;
                end
            endcase
            // flush a partial group with padding
            if (i_last_item && s.pos != 2'd0) begin
                job.data[0] = enc_char(s.accum[23:18]);
                job.data[1] = enc_char(s.accum[17:12]);
                job.data[2] = (s.pos == 2'd2) ? enc_char(s.accum[11:6]) : 8'h3D;
                job.data[3] = 8'h3D;
                job.has     = '1;
                n           = 3'd4;
            end
        end else begin
            if (is_strip) begin
                if (s.strip != 2'd3) s.strip = s.strip + 2'd1;
            end else begin
                // apply held strip characters as bad sextets, then the character
                for (int i = 0; i < 4; i++) begin
                    if (i == 3 || 2'(i) < r_state.strip) begin
                        ds = dec_step(s, (i == 3) ? sextet_of(i_in_byte) : 7'd64,
                                      i_out_limit);
                        s  = ds.st;
                        if (ds.emit) begin
                            job.data[n[1:0]] = ds.dbyte;
                            job.has[n[1:0]]  = 1'b1;
                            n                = n + 3'd1;
                        end
                    end
                end
                s.strip = 2'd0;
            end
            // single character in the final group
            if (i_last_item && !s.err && s.pos == 2'd1) begin
                if (s.marks[0]) begin
                    s.err = 1'b1;
                end else if (s.count < i_out_limit) begin
                    s.count          = s.count + 16'd1;
                    job.data[n[1:0]] = s.accum[23:16];
                    job.has[n[1:0]]  = 1'b1;
                    n                = n + 3'd1;
                end
            end
        end
        // empty result on end of stream or fresh error
        if (n == 3'd0 && (i_last_item || (s.err && !r_state.err))) begin
            n = 3'd1;
        end
        job.cnt  = n;
        job.err  = s.err;
        job.last = i_last_item;
        n_state  = i_last_item ? '0 : s;
    end

    assign o_push = accept && (job.cnt != 3'd0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue: result group queue
// Short FIFO that parts the front from the back.
// ----------------------------------------------------------------------------
module b64_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64_pkg::t_b64_job   i_job,
    input  logic                i_pop,
    output b64_pkg::t_b64_job   o_job,
    output logic                o_full,
    output logic                o_empty
);

    b64_pkg::t_b64_job                 r_mem [b64_pkg::QDEPTH];
    logic [b64_pkg::QPTR_W-1:0]        r_wr;
    logic [b64_pkg::QPTR_W-1:0]        r_rd;
    logic [b64_pkg::QCNT_W-1:0]        r_count;

    assign o_full  = (r_count == b64_pkg::QCNT_W'(b64_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

// File: rtl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back: result drain
// Walks each queued group and presents one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64_pkg::t_b64_job   i_job,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_has_data,
    output logic                o_error_flag,
    output logic                o_last_result
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic       r_err;
    logic       r_last;
    logic       load;
    logic       at_end;

    assign load   = !i_empty && (!r_valid || i_out_ready);
    assign at_end = ({1'b0, r_idx} == (i_job.cnt - 3'd1));
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_job.data[r_idx];
            r_has  <= i_job.has[r_idx];
            r_err  <= i_job.err;
            r_last <= i_job.last && at_end;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_has_data    = r_has;
    assign o_error_flag  = r_err;
    assign o_last_result = r_last;

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> ({1'b0, r_idx} < i_job.cnt))
        else $error("result index past end of group");

    a_pop_resets_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("index not rewound after group");

endmodule

// File: rtl/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and decoder
// Standard alphabet with '=' padding, direction and byte limit set over APB.
// ----------------------------------------------------------------------------
// The codec takes one item per cycle while its two-entry result queue has
// room, and presents one result per cycle on the output while the receiver
// is ready; the single output port sets the sustained rate. Encoding three
// bytes gives four characters; decoding gives at most one result per
// character (held trailing characters never release a byte). An item's
// results are written into the result queue on acceptance, then pass
// through the output register. Each item marked last flushes any partial
// group (with '=' padding when encoding), always yields at least one
// result, the last of them flagged last_result, and clears the stream
// state. In decode, a bad first or second sextet raises error_flag and
// silences the rest of the stream; trailing '=', CR and LF are held and
// only count as bad sextets if more text follows.
// Register 0 (byte 0) is the direction, 0 encode and 1 decode; register 1
// (byte 4) is the most decoded bytes per stream. Write them only while idle.
// ----------------------------------------------------------------------------
module base64_stream_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_item,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_has_data,
    output logic        o_error_flag,
    output logic        o_last_result
);

    logic              r_direction;
    logic [15:0]       r_out_limit;
    logic              cfg_wr;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    b64_pkg::t_b64_job front_job;
    b64_pkg::t_b64_job head_job;

    // Configuration: write on the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= b64_pkg::DIR_ENCODE;
            r_out_limit <= 16'hFFFF;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                b64_pkg::CFG_DIRECTION: r_direction <= pwdata[0];
                b64_pkg::CFG_OUT_LIMIT: r_out_limit <= pwdata[15:0];
                default:                r_direction <= r_direction;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            b64_pkg::CFG_DIRECTION: prdata = {31'd0, r_direction};
            b64_pkg::CFG_OUT_LIMIT: prdata = {16'd0, r_out_limit};
            default:                prdata = '0;
        endcase
    end

    // Front: take items, update stream state, build result groups
    b64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_direction (r_direction),
        .i_out_limit (r_out_limit),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_last_item (i_last_item),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_job       (front_job)
    );

    // Queue: decouple intake from the output handshake
    b64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: drain each group one result at a time
    b64_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_has_data    (o_has_data),
        .o_error_flag  (o_error_flag),
        .o_last_result (o_last_result)
    );

endmodule

// File: tb/b64_stream_checker.sv
// ----------------------------------------------------------------------------
// b64_stream_checker: result predictor and comparator for the base64 codec
// Watches the register port and both item channels, keeps its own copy of
// the stream state, predicts the results of every accepted item and compares
// each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module b64_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port, observed only
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // input channel
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_item,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_has_data,
    input  logic        i_error_flag,
    input  logic        i_last_result,
    // end of run: flag whatever is still outstanding
    input  logic        i_drain_done,
    output int unsigned o_fail_count,
    output int unsigned o_expected_left
);

    localparam logic [7:0] CH_PAD    = 8'h3D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [6:0] NO_SEXTET = 7'd64;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       err;
        logic       fin;
    } t_codec_result;

    b64_pkg::t_b64_state stream_st;
    logic                cfg_direction;
    logic [15:0]         cfg_out_limit;
    t_codec_result       item_results[$];
    t_codec_result       expected_q[$];
    t_codec_result       want;
    logic                leftovers_reported;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        if (s < 6'd26) return "A" + 8'(s);
        if (s < 6'd52) return "a" + 8'(s - 6'd26);
        if (s < 6'd62) return "0" + 8'(s - 6'd52);
        return (s == 6'd62) ? "+" : "/";
    endfunction

    // Alphabet position of a character, NO_SEXTET for anything else
    function automatic logic [6:0] sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        return NO_SEXTET;
    endfunction

    task automatic emit(input logic [7:0] data, input logic has);
        t_codec_result r;
        if (item_results.size() >= b64_pkg::MAX_RES) return;
        r.data = data;
        r.has  = has;
        r.err  = 1'b0;
        r.fin  = 1'b0;
        item_results.push_back(r);
    endtask

    // Decoded bytes past the limit are dropped without a trace
    task automatic emit_decoded(input logic [7:0] data);
        if (stream_st.count < cfg_out_limit) begin
            emit(data, 1'b1);
            stream_st.count = stream_st.count + 16'd1;
        end
    endtask

    task automatic decode_sextet(input logic [6:0] v);
        logic       bad;
        logic [5:0] s;
        bad = v[6];
        s   = bad ? 6'd0 : v[5:0];
        if (stream_st.err) return;
        case (stream_st.pos)
            2'd0: begin
                stream_st.accum = {s, 18'd0};
                stream_st.marks = {1'b0, bad};
                stream_st.pos   = 2'd1;
            end
            2'd1: begin
                stream_st.marks[1] = stream_st.marks[1] | bad;
                stream_st.accum    = stream_st.accum | {6'd0, s, 12'd0};
                stream_st.pos      = 2'd2;
                if (stream_st.marks != 2'd0) begin
                    stream_st.err = 1'b1;
                    return;
                end
                emit_decoded(stream_st.accum[23:16]);
            end
            2'd2: begin
                stream_st.accum = stream_st.accum | {12'd0, s, 6'd0};
                stream_st.pos   = 2'd3;
                if (!bad) emit_decoded(stream_st.accum[15:8]);
            end
            default: begin
                stream_st.accum = stream_st.accum | {18'd0, s};
                stream_st.pos   = 2'd0;
                if (!bad) emit_decoded(stream_st.accum[7:0]);
            end
        endcase
    endtask

    task automatic predict_codec_item(input logic [7:0] b, input logic fin);
        logic          err_before;
        int unsigned   k;
        t_codec_result r;
        err_before = stream_st.err;
        item_results.delete();
        if (cfg_direction == b64_pkg::DIR_ENCODE) begin
            case (stream_st.pos)
                2'd0: begin
                    stream_st.accum = {b, 16'd0};
                    stream_st.pos   = 2'd1;
                end
                2'd1: begin
                    stream_st.accum = stream_st.accum | {8'd0, b, 8'd0};
                    stream_st.pos   = 2'd2;
                end
                default: begin
                    stream_st.accum = stream_st.accum | {16'd0, b};
                    stream_st.pos   = 2'd0;
                    emit(sextet_char(stream_st.accum[23:18]), 1'b1);
                    emit(sextet_char(stream_st.accum[17:12]), 1'b1);
                    emit(sextet_char(stream_st.accum[11:6]), 1'b1);
                    emit(sextet_char(stream_st.accum[5:0]), 1'b1);
                end
            endcase
            if (fin && stream_st.pos != 2'd0) begin
                emit(sextet_char(stream_st.accum[23:18]), 1'b1);
                emit(sextet_char(stream_st.accum[17:12]), 1'b1);
                emit((stream_st.pos == 2'd2) ? sextet_char(stream_st.accum[11:6]) : CH_PAD,
                     1'b1);
                emit(CH_PAD, 1'b1);
            end
        end else begin
            if (b == CH_PAD || b == CH_CR || b == CH_LF) begin
                if (stream_st.strip != 2'd3) stream_st.strip = stream_st.strip + 2'd1;
            end else begin
                // held trailing characters turn into bad sextets
                while (stream_st.strip != 2'd0) begin
                    decode_sextet(NO_SEXTET);
                    stream_st.strip = stream_st.strip - 2'd1;
                end
                decode_sextet(sextet_value(b));
            end
            if (fin && !stream_st.err && stream_st.pos == 2'd1) begin
                if (stream_st.marks[0]) begin
                    stream_st.err = 1'b1;
                end else begin
                    emit_decoded(stream_st.accum[23:16]);
                end
            end
        end
        if (item_results.size() == 0 && (fin || (stream_st.err && !err_before)))
            emit(8'd0, 1'b0);
        for (k = 0; k < item_results.size(); k++) begin
            r     = item_results[k];
            r.err = stream_st.err;
            r.fin = fin && (k == item_results.size() - 1);
            expected_q.push_back(r);
        end
        if (fin) stream_st = '0;
    endtask

    // Compare before predicting: no item can produce a result in its own cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_direction      = b64_pkg::DIR_ENCODE;
            cfg_out_limit      = 16'hFFFF;
            stream_st          = '0;
            o_fail_count       = 0;
            leftovers_reported = 1'b0;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: byte %02h has_data %0b",
                                              i_out_byte, i_has_data));
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_out_byte, want.data));
                    if (i_has_data !== want.has)
                        report_mismatch($sformatf("has_data %0b, expected %0b",
                                                  i_has_data, want.has));
                    if (i_error_flag !== want.err)
                        report_mismatch($sformatf("error_flag %0b, expected %0b",
                                                  i_error_flag, want.err));
                    if (i_last_result !== want.fin)
                        report_mismatch($sformatf("last_result %0b, expected %0b",
                                                  i_last_result, want.fin));
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == b64_pkg::CFG_DIRECTION) begin
                    cfg_direction = pwdata[0];
                end else begin
                    cfg_out_limit = pwdata[15:0];
                end
            end
            if (i_in_valid && i_in_ready)
                predict_codec_item(i_in_byte, i_last_item);
            if (i_drain_done && !leftovers_reported) begin
                if (expected_q.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_q.size()));
                leftovers_reported = 1'b1;
            end
        end
        o_expected_left = expected_q.size();
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the base64 stream codec
// Drives the register port and the item stream, throttles the result side,
// and leaves prediction and comparison to b64_stream_checker. A short
// directed run covers padding, the special decode cases and the byte limit;
// random phases then mix byte streams and mostly well-formed base64 text
// under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned NUM_PHASES      = 7;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned PRESSURE_PHASE  = 6;
    localparam int unsigned HOLD_OFF_CYCLES = 120;
    // settling margin past the result queue and output register of the codec
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned DRAIN_LIMIT     = 20000;
    localparam logic [7:0]  CH_PAD          = 8'h3D;
    localparam logic [7:0]  CH_CR           = 8'h0D;
    localparam logic [7:0]  CH_LF           = 8'h0A;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_last_item;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_has_data;
    logic        o_error_flag;
    logic        o_last_result;

    logic        drain_done;
    int unsigned fail_count;
    int unsigned expected_left;

    // idle percentages of the two sides and a pending receiver hold-off
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned stall_request = 0;
    int unsigned hold_left;

    int unsigned items_sent;
    int unsigned phase_start;
    int unsigned drain_wait;
    logic        phase_dir;
    logic [31:0] phase_limit;
    logic [7:0]  stream_q[$];
    string       alphabet_text =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    base64_stream_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_has_data    (o_has_data),
        .o_error_flag  (o_error_flag),
        .o_last_result (o_last_result)
    );

    b64_stream_checker u_codec_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_last_item     (i_last_item),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_byte      (o_out_byte),
        .i_has_data      (o_has_data),
        .i_error_flag    (o_error_flag),
        .i_last_result   (o_last_result),
        .i_drain_done    (drain_done),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Safety net: a hung handshake ends the run here
    initial begin
        #1000000;
        $display("base64_stream_codec regression: fail");
        $finish;
    end

    // Result side. Either serve a pending hold-off, counted here, or drop
    // ready at random according to the current idle percentage.
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (stall_request != 0) begin
                hold_left = stall_request;
                stall_request <= 0;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Register write with setup and access phases; call at a falling edge. Ends
    // with the bus idle so back-to-back writes never collide in one time step.
    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one item; hold it until accepted. Valid stays high on return so
    // the next item can follow without a bubble.
    task automatic send_item(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_byte   <= b;
        i_last_item <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send the queued stream, marking the final item last when closing it
    task automatic send_stream(input logic close);
        int unsigned k;
        for (k = 0; k < stream_q.size(); k++)
            send_item(stream_q[k], close && (k == stream_q.size() - 1));
        stream_q.delete();
    endtask

    // Drop valid and wait until every predicted result has come out, then
    // let the pipeline run dry in case an item without results is in flight
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_left != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++) stream_q.push_back(s[k]);
    endtask

    // Raw bytes for encoding: mostly short, some longer, extremes favored
    task automatic build_byte_stream();
        int unsigned len;
        int unsigned k;
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(7, 1);
        for (k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0:       stream_q.push_back(8'h00);
                1:       stream_q.push_back(8'hFF);
                default: stream_q.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    // Base64 text for decoding: whole quartets plus a short tail (a tail of
    // two or three usually padded), with line breaks sprinkled in. A small
    // share of characters is noise (any byte, or a stray '=') to break sequences.
    task automatic build_text_stream();
        int unsigned quartets;
        int unsigned tail;
        int unsigned k;
        int unsigned pick;
        logic [7:0]  ch;
        quartets = $urandom_range(3);
        tail     = $urandom_range(3);
        for (k = 0; k < 4 * quartets + tail; k++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                ch = 8'($urandom_range(255));
            end else if (pick < 9) begin
                ch = CH_PAD;
            end else begin
                ch = alphabet_text[$urandom_range(63)];
            end
            stream_q.push_back(ch);
            if ($urandom_range(99) < 6) stream_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
        end
        if (tail >= 2 && $urandom_range(3) != 0)
            repeat (4 - tail) stream_q.push_back(CH_PAD);
        if ($urandom_range(9) == 0) stream_q.push_back(CH_PAD);
        if (stream_q.size() == 0) stream_q.push_back(alphabet_text[$urandom_range(63)]);
    endtask

    initial begin
        // every input known from time zero, reset held low at the start
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_in_byte     = '0;
        i_last_item   = 1'b0;
        drain_done    = 1'b0;
        items_sent    = 0;
        src_idle_pct  = 8;
        sink_idle_pct = 84;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed: encode padding and full groups ---
        apb_write(b64_pkg::CFG_DIRECTION, 32'(b64_pkg::DIR_ENCODE));
        apb_write(b64_pkg::CFG_OUT_LIMIT, 32'h0000_FFFF);
        stream_q.push_back(8'h00);                       // one byte, two pads
        send_stream(1'b1);
        stream_q.push_back(8'hFF);                       // two bytes, one pad
        stream_q.push_back(8'hFE);
        send_stream(1'b1);
        stream_q.push_back(8'hFB);                       // full group of '+'
        stream_q.push_back(8'hEF);
        stream_q.push_back(8'hBE);
        send_stream(1'b1);

        // leave a byte in the group, then finish it in the other direction
        stream_q.push_back(8'h4D);
        send_stream(1'b0);
        settle();
        apb_write(b64_pkg::CFG_DIRECTION, 32'(b64_pkg::DIR_DECODE));
        queue_text("Q");
        send_stream(1'b1);

        // --- directed: decode ---
        queue_text("TWE=");                              // trailing pad dropped at end
        send_stream(1'b1);
        queue_text("Q");                                 // lone character in final group
        send_stream(1'b1);
        queue_text("!QQ");                               // bad first sextet: error, silence
        send_stream(1'b1);
        // three held characters (saturated) applied as bad sextets before 'A'
        queue_text("QQ");
        stream_q.push_back(CH_CR);
        stream_q.push_back(CH_PAD);
        stream_q.push_back(CH_LF);
        queue_text("A");
        send_stream(1'b1);
        settle();
        apb_write(b64_pkg::CFG_OUT_LIMIT, 32'd1);        // keep only the first byte
        queue_text("QUJD");
        send_stream(1'b1);

        // --- random phases ---
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: begin phase_dir = b64_pkg::DIR_ENCODE; phase_limit = 32'h0000_FFFF; end
                1: begin phase_dir = b64_pkg::DIR_DECODE; phase_limit = 32'h0000_FFFF; end
                2: begin phase_dir = b64_pkg::DIR_DECODE; phase_limit = 32'd0;         end
                3: begin phase_dir = b64_pkg::DIR_ENCODE; phase_limit = 32'd0;         end
                4: begin phase_dir = b64_pkg::DIR_DECODE; phase_limit = 32'd3;         end
                5: begin phase_dir = b64_pkg::DIR_DECODE; phase_limit = 32'h0000_FFFF; end
                default: begin
                    phase_dir   = b64_pkg::DIR_ENCODE;
                    phase_limit = 32'd7;
                end
            endcase
            apb_write(b64_pkg::CFG_DIRECTION, 32'(phase_dir));
            apb_write(b64_pkg::CFG_OUT_LIMIT, phase_limit);

            // sender rarely idle / receiver mostly stalled, then swapped,
            // then both sides at full speed
            if (p < 2) begin
                src_idle_pct = 8;
                sink_idle_pct <= 84;
            end else if (p < 4) begin
                src_idle_pct = 84;
                sink_idle_pct <= 8;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct <= 0;
            end
            // hold the receiver off while items keep coming, so the result
            // queue fills and the codec stalls its input
            if (p == PRESSURE_PHASE) stall_request <= HOLD_OFF_CYCLES;

            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                if (phase_dir == b64_pkg::DIR_ENCODE) begin
                    build_byte_stream();
                end else begin
                    build_text_stream();
                end
                // the final stream of a phase is sometimes left open, so the
                // next phase continues its state under the new settings
                send_stream(items_sent - phase_start + stream_q.size() < ITEMS_PER_PHASE
                            || $urandom_range(3) != 0);
            end
        end

        // --- wind down: drain, let the pipeline empty, collect the verdict ---
        i_in_valid <= 1'b0;
        drain_wait = 0;
        while (expected_left != 0 && drain_wait < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        drain_done <= 1'b1;
        repeat (2) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("base64_stream_codec regression: pass");
        end else begin
            $display("base64_stream_codec regression: fail");
        end
        $finish;
    end

endmodule
